[sv/roll_point_ring_sampler_macros.svh]
// Assertion macros used by the roll point ring sampler checker.
`ifndef ROLL_POINT_RING_SAMPLER_MACROS_SVH
`define ROLL_POINT_RING_SAMPLER_MACROS_SVH

// Checked at every edge once out of reset.
`define RPRS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define RPRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/rprs_pkg.sv]
// Types and constants of the roll point ring sampler.
package rprs_pkg;

    localparam int IN_DATA_W   = 64;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 112;
    localparam int POS_W       = 9;
    localparam int COUNT_OUT_W = 9;
    localparam int CNT16_W     = 16;
    localparam int BACKOFF_W   = 4;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [CNT16_W-1:0]   PACER_PERIOD_RST = 16'hFFFF;
    localparam logic [BACKOFF_W-1:0] BACKOFF_RST      = 4'd4;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_START = 2'd2,
        CMD_STOP  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE       = 2'd0,
        ST_NO_SOURCE  = 2'd1,
        ST_READ_ERROR = 2'd2,
        ST_STORED     = 2'd3
    } status_t;

    typedef enum logic {
        REG_PACER_PERIOD = 1'b0,
        REG_BACKOFF      = 1'b1
    } reg_idx_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } ctrl_state_t;

    // Lowest bit is the last member.
    typedef struct packed {
        logic [3:0]         pad;
        logic [POS_W-1:0]   read_position;
        logic               wrapped_during_read;
        logic [CNT16_W-1:0] timer_after;
        logic [CNT16_W-1:0] timer_before;
        logic [7:0]         ch2_sample;
        logic [7:0]         ch1_sample;
        logic               point_valid;
        logic               source_ready;
    } in_item_t;

    typedef struct packed {
        logic [2:0]             pad;
        logic                   stored;
        logic [CNT16_W-1:0]     frame_count;
        logic [CNT16_W-1:0]     error_count;
        status_t                last_status;
        logic [CNT16_W-1:0]     overrun_count;
        logic [CNT16_W-1:0]     worst_cost;
        logic [CNT16_W-1:0]     sequence_res;
        logic [COUNT_OUT_W-1:0] point_count;
        logic                   read_ok;
        logic [7:0]             ch2_out;
        logic [7:0]             ch1_out;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

[sv/rprs_ctrl.sv]
// Controller: accept a transaction, then commit it once the output slot is free.
module rprs_ctrl
    import rprs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (status.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                // nothing is taken while in reset
                s_tready = aresetn;
                cmd.load = s_tvalid && aresetn;
            end
            S_EXEC: begin
                cmd.commit = status.out_free;
            end
            default: ;
        endcase
    end

endmodule

[sv/rprs_datapath.sv]
// Datapath: ring memory, sampler state, statistics and the result register.
module rprs_datapath
    import rprs_pkg::*;
#(
    parameter int RING_DEPTH = 300
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic [CNT16_W-1:0]    cfg_pacer_period,
    input  logic [BACKOFF_W-1:0]  cfg_backoff
);

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = ((PTR_W > POS_W) ? PTR_W : POS_W) + 1;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(RING_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM  = SUM_W'(RING_DEPTH);

    logic [15:0] ring_mem [RING_DEPTH];

    // Captured transaction
    in_item_t           item_reg;
    cmd_t               kind_reg;
    logic [CNT16_W-1:0] cost_reg;
    logic               rd_ok_reg;
    logic [15:0]        rd_data_reg;

    // Sampler state
    logic [PTR_W-1:0]     wp_reg, wp_next;
    logic [CNT_W-1:0]     held_reg, held_next;
    logic [CNT16_W-1:0]   seq_reg, seq_next;
    logic [CNT16_W-1:0]   max_reg, max_next;
    logic [CNT16_W-1:0]   ovr_reg, ovr_next;
    logic [BACKOFF_W-1:0] backoff_reg, backoff_next;
    logic                 en_reg, en_next;
    status_t              status_reg, status_next;
    logic [CNT16_W-1:0]   err_reg, err_next;
    logic [CNT16_W-1:0]   frames_reg, frames_next;
    logic                 store;

    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    // Load-side decode
    in_item_t           in_item;
    logic               pos_ok;
    logic [PTR_W-1:0]   start_ptr;
    logic [SUM_W-1:0]   sum;
    logic [PTR_W-1:0]   rd_addr;
    logic [CNT16_W-1:0] diff;
    logic [CNT16_W-1:0] cost;
    out_item_t          out_next;

    assign in_item = in_item_t'(s_tdata);

    always_comb begin
        pos_ok    = CMP_W'(in_item.read_position) < CMP_W'(held_reg);
        start_ptr = (held_reg == FULL_COUNT) ? wp_reg : '0;
        sum       = SUM_W'(start_ptr) + SUM_W'(in_item.read_position);
        if (sum >= DEPTH_SUM) begin
            sum = sum - DEPTH_SUM;
        end
        rd_addr = sum[PTR_W-1:0];
        diff    = in_item.timer_after - in_item.timer_before;
        cost    = (in_item.timer_after < in_item.timer_before)
                ? diff + (cfg_pacer_period + 16'd1) : diff;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg  <= in_item;
            kind_reg  <= cmd_t'(s_tuser);
            cost_reg  <= cost;
            rd_ok_reg <= pos_ok && (cmd_t'(s_tuser) == CMD_READ);
        end
    end

    // Ring memory: read on load of an in-range read, write on commit of a stored point.
    always_ff @(posedge aclk) begin
        if (cmd.load && pos_ok && (cmd_t'(s_tuser) == CMD_READ)) begin
            rd_data_reg <= ring_mem[rd_addr];
        end
        if (store) begin
            ring_mem[wp_reg] <= {item_reg.ch2_sample, item_reg.ch1_sample};
        end
    end

    always_comb begin
        wp_next      = wp_reg;
        held_next    = held_reg;
        seq_next     = seq_reg;
        max_next     = max_reg;
        ovr_next     = ovr_reg;
        backoff_next = backoff_reg;
        en_next      = en_reg;
        status_next  = status_reg;
        err_next     = err_reg;
        frames_next  = frames_reg;
        store        = 1'b0;
        if (cmd.commit) begin
            unique case (kind_reg)
                CMD_TICK: begin
                    if (!en_reg) begin
                        // sampler off: ignored
                    end else if (backoff_reg != '0) begin
                        backoff_next = backoff_reg - 4'd1;
                    end else if (!item_reg.source_ready) begin
                        status_next = ST_READ_ERROR;
                        err_next    = err_reg + 16'd1;
                    end else if (item_reg.point_valid) begin
                        store = 1'b1;
                        if (item_reg.wrapped_during_read) begin
                            ovr_next     = ovr_reg + 16'd1;
                            backoff_next = cfg_backoff;
                        end else if (cost_reg > max_reg) begin
                            max_next = cost_reg;
                        end
                        wp_next     = (wp_reg == LAST_PTR) ? '0 : wp_reg + PTR_W'(1);
                        held_next   = (held_reg == FULL_COUNT) ? held_reg
                                    : held_reg + CNT_W'(1);
                        seq_next    = seq_reg + 16'd1;
                        status_next = ST_STORED;
                        frames_next = frames_reg + 16'd1;
                    end
                end
                CMD_READ: ;
                CMD_START: begin
                    wp_next      = '0;
                    held_next    = '0;
                    max_next     = '0;
                    ovr_next     = '0;
                    backoff_next = '0;
                    seq_next     = seq_reg + 16'd1;
                    en_next      = item_reg.source_ready;
                    if (!item_reg.source_ready) begin
                        status_next = ST_NO_SOURCE;
                        err_next    = err_reg + 16'd1;
                    end
                end
                CMD_STOP: en_next = 1'b0;
                default: ;
            endcase
        end
    end

    always_comb begin
        out_next               = '0;
        out_next.ch1_out       = rd_ok_reg ? rd_data_reg[7:0] : 8'd0;
        out_next.ch2_out       = rd_ok_reg ? rd_data_reg[15:8] : 8'd0;
        out_next.read_ok       = rd_ok_reg;
        out_next.point_count   = COUNT_OUT_W'(held_next);
        out_next.sequence_res  = seq_next;
        out_next.worst_cost    = max_next;
        out_next.overrun_count = ovr_next;
        out_next.last_status   = status_next;
        out_next.error_count   = err_next;
        out_next.frame_count   = frames_next;
        out_next.stored        = store;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg       <= '0;
            held_reg     <= '0;
            seq_reg      <= '0;
            max_reg      <= '0;
            ovr_reg      <= '0;
            backoff_reg  <= '0;
            en_reg       <= 1'b0;
            status_reg   <= ST_IDLE;
            err_reg      <= '0;
            frames_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            wp_reg      <= wp_next;
            held_reg    <= held_next;
            seq_reg     <= seq_next;
            max_reg     <= max_next;
            ovr_reg     <= ovr_next;
            backoff_reg <= backoff_next;
            en_reg      <= en_next;
            status_reg  <= status_next;
            err_reg     <= err_next;
            frames_reg  <= frames_next;
            if (cmd.commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_tdata_reg <= out_next;
        end
    end

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;

endmodule

[sv/roll_point_ring_sampler.sv]
// Roll point ring sampler: top level with configuration registers.
// A transaction is captured on accept; its result is registered on commit, once the output slot is free.
// No new transaction is taken until the last one commits; the accept reads the single ring port,
// the commit updates the state and writes the ring. A result waiting on m_tready holds
// the next commit; one more transaction may enter first, then s_tready stays low.
// Reset (aresetn low, synchronous): pointers, counters, status, config to defaults; ring kept.
module roll_point_ring_sampler
    import rprs_pkg::*;
#(
    parameter int RING_DEPTH = 300
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata, low bit up: source_ready, point_valid, ch1_sample[8], ch2_sample[8],
    // timer_before[16], timer_after[16], wrapped_during_read, read_position[9], zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // s_tuser: cmd[2]
    input  logic [IN_USER_W-1:0]  s_tuser,
    // Result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata, low bit up: ch1_out[8], ch2_out[8], read_ok, point_count[9],
    // sequence_res[16], worst_cost[16], overrun_count[16], last_status[2],
    // error_count[16], frame_count[16], stored, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CNT16_W-1:0]   pacer_period_reg;
    logic [BACKOFF_W-1:0] backoff_ticks_reg;
    logic                 cfg_wr;
    reg_idx_t             cfg_idx;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Registers sit at byte addresses 0 and 4; paddr[2] picks one, the low bits are ignored.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pacer_period_reg  <= PACER_PERIOD_RST;
            backoff_ticks_reg <= BACKOFF_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_PACER_PERIOD: pacer_period_reg  <= pwdata[CNT16_W-1:0];
                REG_BACKOFF:      backoff_ticks_reg <= pwdata[BACKOFF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_PACER_PERIOD: prdata = APB_DATA_W'(pacer_period_reg);
            REG_BACKOFF:      prdata = APB_DATA_W'(backoff_ticks_reg);
            default: ;
        endcase
    end

    // Controller: two-state sequencer, accept then commit.
    rprs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: ring memory, statistics and the output register.
    rprs_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .cfg_pacer_period (pacer_period_reg),
        .cfg_backoff      (backoff_ticks_reg)
    );

endmodule

[sv/rprs_checker.sv]
// Port-level checker for the roll point ring sampler, bound to the top level.
`include "roll_point_ring_sampler_macros.svh"

module rprs_checker
    import rprs_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    out_item_t res;

    assign res = out_item_t'(m_tdata);

    `RPRS_ASSERT_ALWAYS(a_reset_clears_valid, aclk, !aresetn |=> !m_tvalid, "m_tvalid after reset")
    `RPRS_ASSERT(a_one_per_two, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "back-to-back accept")
    `RPRS_ASSERT(a_stored_status, aclk, aresetn, m_tvalid && res.stored |-> res.last_status == ST_STORED, "stored without stored status")
    `RPRS_ASSERT(a_bad_read_zero, aclk, aresetn, m_tvalid && !res.read_ok |-> res.ch1_out == 8'd0 && res.ch2_out == 8'd0, "point bytes without read_ok")
    `RPRS_ASSERT(a_result_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind roll_point_ring_sampler rprs_checker u_rprs_checker (.*);
